/* src/sme_pkg.sv */
`timescale 1ns / 1ps
// Package for the stack machine execute block: sizes, opcodes, status codes
// and sequencer states. No dependencies.
package sme_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int STK_AW      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = STK_AW + 1;
    localparam int VAR_SLOTS   = 64;
    localparam int VAR_AW      = $clog2(VAR_SLOTS);
    localparam int PC_W        = 10;
    localparam int DIV_STEPS   = 32;

    typedef enum logic [4:0] {
        OP_PUSHC  = 5'd0,
        OP_PUSHV  = 5'd1,
        OP_POPV   = 5'd2,
        OP_JMP    = 5'd3,
        OP_BRT    = 5'd4,
        OP_BRF    = 5'd5,
        OP_SIGEN  = 5'd6,
        OP_SIGDIS = 5'd7,
        OP_PRINTC = 5'd8,
        OP_PRINTV = 5'd9,
        OP_HALT   = 5'd10,
        OP_NOP    = 5'd11,
        OP_ADD    = 5'd12,
        OP_SUB    = 5'd13,
        OP_MUL    = 5'd14,
        OP_DIV    = 5'd15,
        OP_AND    = 5'd16,
        OP_OR     = 5'd17,
        OP_LT     = 5'd18,
        OP_LEQ    = 5'd19,
        OP_GT     = 5'd20,
        OP_GEQ    = 5'd21,
        OP_EQ     = 5'd22,
        OP_NEQ    = 5'd23
    } t_op;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_OVERFLOW  = 3'd1,
        ST_UNDERFLOW = 3'd2,
        ST_DIV_ZERO  = 3'd3,
        ST_HALTED    = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EXEC,
        S_DIV,
        S_DONE
    } t_state;

endpackage

/* src/stack_machine_execute_top.sv */
`timescale 1ns / 1ps
// Sequence: read, execute, divide for a div that proceeds (one quotient bit per
// cycle in the restoring divider), then done, which waits out any output stall.
// One instruction in flight at a time; next beat is taken once the sequencer
// returns to idle. Reset (synchronous, active low) clears the stack count,
// program counter, flags and variable valid bits at once.
// Top level of the stack machine execute block; uses sme_pkg.
module stack_machine_execute_top (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [4:0]              i_req_type,
    input  logic signed [31:0]      i_constant,
    input  logic [5:0]              i_var_slot,
    input  logic [9:0]              i_jump_target,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [sme_pkg::PC_W-1:0] o_next_pc,
    output logic signed [31:0]      o_top_value,
    output logic [6:0]              o_stack_depth,
    output logic                    o_print_valid,
    output logic signed [31:0]      o_print_value,
    output logic                    o_halted,
    output logic                    o_interrupts_enabled,
    output logic [2:0]              o_status
);
    import sme_pkg::*;

    t_state r_state, n_state;

    // captured instruction
    logic [4:0]        r_op;
    logic [31:0]       r_k;
    logic [VAR_AW-1:0] r_slot;
    logic [PC_W-1:0]   r_tgt;

    // architectural state
    logic [CNT_W-1:0]  r_cnt;
    logic [31:0]       r_top;
    logic [PC_W-1:0]   r_pc;
    logic              r_halt;
    logic              r_ie;
    logic [31:0]       r_stk [STACK_DEPTH];
    logic [31:0]       r_var [VAR_SLOTS];
    logic [VAR_SLOTS-1:0] r_var_vld;

    // registered memory reads
    logic [31:0]       r_stk_rd;
    logic [31:0]       r_var_rd;
    logic              r_var_rd_vld;

    // per-item result
    logic              r_pv;
    logic [31:0]       r_pval;
    logic [2:0]        r_status;

    // divider
    logic [32:0]       r_rem;
    logic [31:0]       r_quo;
    logic [31:0]       r_dvsr;
    logic [4:0]        r_dcnt;
    logic              r_qneg;

    logic              in_acc;
    logic              out_free;
    logic [CNT_W-1:0]  cnt_m1;
    logic [CNT_W-1:0]  cnt_m2;
    logic [31:0]       var_val;
    logic [31:0]       a_val;
    logic [31:0]       b_val;
    logic [31:0]       alu_res;
    logic [32:0]       rem_sh;
    logic [32:0]       rem_diff;
    logic              q_bit;
    logic [31:0]       quo_nx;
    logic [PC_W-1:0]   pc_inc;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !o_out_valid || !i_out_stall;
    assign cnt_m1   = r_cnt - CNT_W'(1);
    assign cnt_m2   = r_cnt - CNT_W'(2);
    assign var_val  = r_var_rd_vld ? r_var_rd : 32'd0;
    assign a_val    = r_top;
    assign b_val    = r_stk_rd;
    assign pc_inc   = r_pc + PC_W'(1);

    // shared arithmetic, logic and compare unit for the two-operand operations but div
    always_comb begin
        case (r_op)
            OP_ADD:  alu_res = b_val + a_val;
            OP_SUB:  alu_res = b_val - a_val;
            OP_AND:  alu_res = {31'd0, (a_val != 32'd0) && (b_val != 32'd0)};
            OP_OR:   alu_res = {31'd0, (a_val != 32'd0) || (b_val != 32'd0)};
            OP_LT:   alu_res = {31'd0, $signed(b_val) <  $signed(a_val)};
            OP_LEQ:  alu_res = {31'd0, $signed(b_val) <= $signed(a_val)};
            OP_GT:   alu_res = {31'd0, $signed(b_val) >  $signed(a_val)};
            OP_GEQ:  alu_res = {31'd0, $signed(b_val) >= $signed(a_val)};
            OP_EQ:   alu_res = {31'd0, a_val == b_val};
            OP_MUL:  alu_res = b_val * a_val;
            default: alu_res = {31'd0, a_val != b_val};
        endcase
    end

    // one restoring division step
    assign rem_sh   = {r_rem[31:0], r_quo[31]};
    assign rem_diff = rem_sh - {1'b0, r_dvsr};
    assign q_bit    = !rem_diff[32];
    assign quo_nx   = {r_quo[30:0], q_bit};

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and input stall
    always_comb begin
        n_state    = r_state;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) n_state = S_READ;
            end
            S_READ: n_state = S_EXEC;
            S_EXEC: begin
                if (!r_halt && r_op == OP_DIV && r_cnt >= CNT_W'(2) && a_val != 32'd0) begin
                    n_state = S_DIV;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DIV: if (r_dcnt == 5'(DIV_STEPS - 1)) n_state = S_DONE;
            S_DONE: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control state: count, pc, flags, variable valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_pc      <= '0;
            r_halt    <= 1'b0;
            r_ie      <= 1'b0;
            r_var_vld <= '0;
        end else if (r_state == S_EXEC && !r_halt) begin
            case (r_op)
                OP_PUSHC, OP_PUSHV: begin
                    if (!r_cnt[STK_AW]) begin
                        r_cnt <= r_cnt + CNT_W'(1);
                        r_pc  <= pc_inc;
                    end
                end
                OP_POPV, OP_BRT, OP_BRF: begin
                    if (r_cnt != '0) begin
                        r_cnt <= cnt_m1;
                        if ((r_op == OP_BRT && a_val != 32'd0) ||
                            (r_op == OP_BRF && a_val == 32'd0)) begin
                            r_pc <= r_tgt;
                        end else begin
                            r_pc <= pc_inc;
                        end
                        if (r_op == OP_POPV) r_var_vld[r_slot] <= 1'b1;
                    end
                end
                OP_JMP:    r_pc <= r_tgt;
                OP_SIGEN:  begin r_ie <= 1'b1; r_pc <= pc_inc; end
                OP_SIGDIS: begin r_ie <= 1'b0; r_pc <= pc_inc; end
                OP_HALT:   begin r_halt <= 1'b1; r_pc <= pc_inc; end
                OP_ADD, OP_SUB, OP_MUL, OP_AND, OP_OR, OP_LT, OP_LEQ,
                OP_GT, OP_GEQ, OP_EQ, OP_NEQ: begin
                    if (r_cnt >= CNT_W'(2)) begin
                        r_cnt <= cnt_m1;
                        r_pc  <= pc_inc;
                    end
                end
                OP_DIV: ;
                default: r_pc <= pc_inc;
            endcase
        end else if (r_state == S_DIV && r_dcnt == 5'(DIV_STEPS - 1)) begin
            r_cnt <= cnt_m1;
            r_pc  <= pc_inc;
        end
    end

    // datapath: capture, memory reads, execute, divide
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op   <= i_req_type;
            r_k    <= i_constant;
            r_slot <= i_var_slot;
            r_tgt  <= i_jump_target;
        end
        if (r_state == S_READ) begin
            r_stk_rd     <= r_stk[cnt_m2[STK_AW-1:0]];
            r_var_rd     <= r_var[r_slot];
            r_var_rd_vld <= r_var_vld[r_slot];
        end
        if (r_state == S_EXEC) begin
            r_pv     <= 1'b0;
            r_pval   <= 32'd0;
            r_status <= ST_OK;
            if (r_halt) begin
                r_status <= ST_HALTED;
            end else begin
                case (r_op)
                    OP_PUSHC, OP_PUSHV: begin
                        if (r_cnt[STK_AW]) begin
                            r_status <= ST_OVERFLOW;
                        end else begin
                            if (r_cnt != '0) r_stk[cnt_m1[STK_AW-1:0]] <= r_top;
                            r_top <= (r_op == OP_PUSHC) ? r_k : var_val;
                        end
                    end
                    OP_POPV, OP_BRT, OP_BRF: begin
                        if (r_cnt == '0) begin
                            r_status <= ST_UNDERFLOW;
                        end else begin
                            r_top <= b_val;
                            if (r_op == OP_POPV) r_var[r_slot] <= a_val;
                        end
                    end
                    OP_PRINTC: begin r_pv <= 1'b1; r_pval <= r_k; end
                    OP_PRINTV: begin r_pv <= 1'b1; r_pval <= var_val; end
                    OP_DIV: begin
                        if (r_cnt < CNT_W'(2)) begin
                            r_status <= ST_UNDERFLOW;
                        end else if (a_val == 32'd0) begin
                            r_status <= ST_DIV_ZERO;
                        end else begin
                            r_rem  <= 33'd0;
                            r_quo  <= b_val[31] ? 32'd0 - b_val : b_val;
                            r_dvsr <= a_val[31] ? 32'd0 - a_val : a_val;
                            r_qneg <= b_val[31] ^ a_val[31];
                            r_dcnt <= 5'd0;
                        end
                    end
                    OP_ADD, OP_SUB, OP_MUL, OP_AND, OP_OR, OP_LT, OP_LEQ,
                    OP_GT, OP_GEQ, OP_EQ, OP_NEQ: begin
                        if (r_cnt < CNT_W'(2)) begin
                            r_status <= ST_UNDERFLOW;
                        end else begin
                            r_top <= alu_res;
                        end
                    end
                    default: ;
                endcase
            end
        end
        // advance the divider one bit
        if (r_state == S_DIV) begin
            r_rem  <= q_bit ? rem_diff : rem_sh;
            r_quo  <= quo_nx;
            r_dcnt <= r_dcnt + 5'd1;
            if (r_dcnt == 5'(DIV_STEPS - 1)) begin
                r_top <= r_qneg ? 32'd0 - quo_nx : quo_nx;
            end
        end
    end

    // output register: load when the sequencer finishes and the slot is free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_halted <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            o_halted <= r_halt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            o_next_pc            <= r_pc;
            o_top_value          <= (r_cnt != '0) ? r_top : 32'd0;
            o_stack_depth        <= 7'(r_cnt);
            o_print_valid        <= r_pv;
            o_print_value        <= r_pval;
            o_interrupts_enabled <= r_ie;
            o_status             <= r_status;
        end
    end

endmodule

/* src/sme_checker.sv */
`timescale 1ns / 1ps
// Port-level checker for the stack machine execute block, bound to the top
// level below. Uses only the top level's ports.
module sme_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [9:0]  o_next_pc,
    input logic [31:0] o_top_value,
    input logic [6:0]  o_stack_depth,
    input logic        o_print_valid,
    input logic        o_halted,
    input logic [2:0]  o_status
);
    // hold a stalled result beat
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_next_pc))
        else $error("stalled result beat changed");

    // halt is sticky
    a_halt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(o_halted) |-> o_halted)
        else $error("halt flag dropped");

    // errors and ignored beats never print
    a_err_print: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != 3'd0 |-> !o_print_valid)
        else $error("print on failed instruction");

    // empty stack shows zero top
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_stack_depth == 7'd0 |-> o_top_value == 32'd0)
        else $error("nonzero top on empty stack");

    // depth stays within the stack
    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_stack_depth <= 7'd64)
        else $error("stack depth out of range");

endmodule

bind stack_machine_execute_top sme_checker u_sme_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_next_pc     (o_next_pc),
    .o_top_value   (o_top_value),
    .o_stack_depth (o_stack_depth),
    .o_print_valid (o_print_valid),
    .o_halted      (o_halted),
    .o_status      (o_status)
);

/* tb/sv/tb_stack_machine_execute_top.sv */
`timescale 1ns / 1ps
// Testbench for stack_machine_execute_top: directed and random instruction
// streams, checked against an in-bench model of the stack machine.
// Depends on sme_pkg and the RTL top level only.

class exec_scoreboard;
    // machine state mirrored from the block
    logic [31:0] stk [64];
    logic [31:0] vars [64];
    int unsigned depth;
    logic [9:0]  pc;
    bit          halt_f;
    bit          irq_en;

    // expected result beats, oldest first
    logic [9:0]  q_pc [$];
    logic [31:0] q_top [$];
    logic [6:0]  q_depth [$];
    bit          q_pv [$];
    logic [31:0] q_pval [$];
    bit          q_halt [$];
    bit          q_irq [$];
    logic [2:0]  q_status [$];
    int          errors;
    int          checked;

    function new();
        foreach (vars[i]) vars[i] = '0;
        depth = 0; pc = '0; halt_f = 0; irq_en = 0; errors = 0; checked = 0;
    endfunction

    function logic [31:0] alu_result(logic [4:0] op, logic [31:0] b, logic [31:0] a);
        logic signed [31:0] sb, sa;
        logic [31:0] mb, ma, q;
        sb = b; sa = a;
        case (op)
            sme_pkg::OP_ADD: return b + a;
            sme_pkg::OP_SUB: return b - a;
            sme_pkg::OP_MUL: return b * a;
            sme_pkg::OP_DIV: begin
                mb = b[31] ? -b : b;
                ma = a[31] ? -a : a;
                q = mb / ma;
                return (b[31] != a[31]) ? -q : q;
            end
            sme_pkg::OP_AND: return (a != 0 && b != 0);
            sme_pkg::OP_OR:  return (a != 0 || b != 0);
            sme_pkg::OP_LT:  return sb < sa;
            sme_pkg::OP_LEQ: return sb <= sa;
            sme_pkg::OP_GT:  return sb > sa;
            sme_pkg::OP_GEQ: return sb >= sa;
            sme_pkg::OP_EQ:  return a == b;
            default:         return a != b;
        endcase
    endfunction

    // note an accepted instruction beat and queue its expected result
    function void note_instr(logic [4:0] op, logic [31:0] k, logic [5:0] slot,
                             logic [9:0] tgt);
        logic [2:0]  st;
        bit          pv;
        logic [31:0] pval, t;
        logic [9:0]  npc;
        st = sme_pkg::ST_OK; pv = 0; pval = '0; npc = pc + 10'd1;
        if (halt_f) begin
            st = sme_pkg::ST_HALTED;
        end else if (op == sme_pkg::OP_PUSHC || op == sme_pkg::OP_PUSHV) begin
            if (depth >= 64) st = sme_pkg::ST_OVERFLOW;
            else begin
                stk[depth] = (op == sme_pkg::OP_PUSHC) ? k : vars[slot];
                depth++;
            end
        end else if (op == sme_pkg::OP_POPV || op == sme_pkg::OP_BRT
                     || op == sme_pkg::OP_BRF) begin
            if (depth < 1) st = sme_pkg::ST_UNDERFLOW;
            else begin
                t = stk[depth-1];
                depth--;
                if (op == sme_pkg::OP_POPV) vars[slot] = t;
                else if ((op == sme_pkg::OP_BRT && t != 0)
                         || (op == sme_pkg::OP_BRF && t == 0)) npc = tgt;
            end
        end else if (op == sme_pkg::OP_JMP) npc = tgt;
        else if (op == sme_pkg::OP_SIGEN) irq_en = 1;
        else if (op == sme_pkg::OP_SIGDIS) irq_en = 0;
        else if (op == sme_pkg::OP_PRINTC) begin
            pv = 1; pval = k;
        end else if (op == sme_pkg::OP_PRINTV) begin
            pv = 1; pval = vars[slot];
        end else if (op == sme_pkg::OP_HALT) halt_f = 1;
        else if (op >= sme_pkg::OP_ADD && op <= sme_pkg::OP_NEQ) begin
            if (depth < 2) st = sme_pkg::ST_UNDERFLOW;
            else if (op == sme_pkg::OP_DIV && stk[depth-1] == 0) st = sme_pkg::ST_DIV_ZERO;
            else begin
                stk[depth-2] = alu_result(op, stk[depth-2], stk[depth-1]);
                depth--;
            end
        end
        if (st == sme_pkg::ST_OK) pc = npc;
        q_pc.push_back(pc);
        q_top.push_back(depth ? stk[depth-1] : 32'd0);
        q_depth.push_back(depth[6:0]);
        q_pv.push_back(pv);
        q_pval.push_back(pval);
        q_halt.push_back(halt_f);
        q_irq.push_back(irq_en);
        q_status.push_back(st);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
        $display("ERROR result %0d: %s got %0h expected %0h", checked, what, got, want);
        errors++;
    endtask

    // compare one result beat with the oldest expectation
    task check_result(logic [9:0] r_pc, logic [31:0] r_top, logic [6:0] r_depth,
                      bit r_pv, logic [31:0] r_pval, bit r_halt, bit r_irq,
                      logic [2:0] r_status);
        logic [9:0] e_pc; logic [31:0] e_top, e_pval; logic [6:0] e_depth;
        bit e_pv, e_halt, e_irq; logic [2:0] e_status;
        if (q_pc.size() == 0) begin
            $display("ERROR unexpected result beat");
            errors++;
            return;
        end
        e_pc = q_pc.pop_front(); e_top = q_top.pop_front();
        e_depth = q_depth.pop_front(); e_pv = q_pv.pop_front();
        e_pval = q_pval.pop_front(); e_halt = q_halt.pop_front();
        e_irq = q_irq.pop_front(); e_status = q_status.pop_front();
        if (r_pc !== e_pc) report("next_pc", r_pc, e_pc);
        if (r_top !== e_top) report("top_value", r_top, e_top);
        if (r_depth !== e_depth) report("stack_depth", r_depth, e_depth);
        if (r_pv !== e_pv) report("print_valid", r_pv, e_pv);
        if (r_pval !== e_pval) report("print_value", r_pval, e_pval);
        if (r_halt !== e_halt) report("halted", r_halt, e_halt);
        if (r_irq !== e_irq) report("interrupts_enabled", r_irq, e_irq);
        if (r_status !== e_status) report("status", r_status, e_status);
        checked++;
    endtask
endclass

module tb_stack_machine_execute_top;
    import sme_pkg::*;

    localparam int CYCLE_LIMIT = 900000;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_in_valid = 0;
    logic        o_in_stall;
    logic [4:0]  i_req_type = '0;
    logic signed [31:0] i_constant = '0;
    logic [5:0]  i_var_slot = '0;
    logic [9:0]  i_jump_target = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1;
    logic [PC_W-1:0] o_next_pc;
    logic signed [31:0] o_top_value, o_print_value;
    logic [6:0]  o_stack_depth;
    logic        o_print_valid, o_halted, o_interrupts_enabled;
    logic [2:0]  o_status;

    exec_scoreboard sb;
    int  cycles = 0;
    int  sent = 0;
    bit  hold_out = 0;
    int  model_depth;

    stack_machine_execute_top u_top (.*);

    always begin
        #10 i_clk = 1;
        #10 i_clk = 0;
    end

    // stop a hung run
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // note instructions and check results at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall)
            sb.note_instr(i_req_type, i_constant, i_var_slot, i_jump_target);
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_next_pc, o_top_value, o_stack_depth, o_print_valid,
                            o_print_value, o_halted, o_interrupts_enabled, o_status);
    end

    function int gap_len();
        if ($urandom_range(0, 2) == 0) return 0;
        return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    endfunction

    // output stall: off for part of each period, else random, or held high for a long stretch on request
    initial begin
        int n;
        @(negedge i_clk);
        while (1) begin
            if (hold_out) begin
                i_out_stall <= 1;
                repeat (300) @(negedge i_clk);
                hold_out = 0;
            end else if (cycles % 4000 < 1500) begin
                i_out_stall <= 0;
                @(negedge i_clk);
            end else begin
                n = gap_len();
                i_out_stall <= (n != 0);
                repeat (n > 0 ? n : 1) @(negedge i_clk);
                i_out_stall <= 0;
                @(negedge i_clk);
            end
        end
    end

    // offer one beat and hold it until taken; valid stays up for the next beat
    task send_instr(logic [4:0] op, logic [31:0] k, logic [5:0] slot, logic [9:0] tgt);
        i_in_valid <= 1;
        i_req_type <= op;
        i_constant <= k;
        i_var_slot <= slot;
        i_jump_target <= tgt;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sent++;
        @(negedge i_clk);
    endtask

    task send_gap(logic [4:0] op, logic [31:0] k, logic [5:0] slot, logic [9:0] tgt);
        int n;
        send_instr(op, k, slot, tgt);
        if (cycles % 3000 > 600) begin
            n = gap_len();
            if (n > 0) begin
                i_in_valid <= 0;
                repeat (n) @(negedge i_clk);
            end
        end
    endtask

    function logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return 32'd0;
            4: return $urandom_range(0, 9);
            default: return $urandom;
        endcase
    endfunction

    task drain();
        i_in_valid <= 0;
        while (sb.q_pc.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    initial begin
        int r;
        logic [4:0] op;
        sb = new();
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // directed: underflows on empty stack, overflow, div by zero, extremes, every operation
        send_instr(OP_POPV, 0, 6'd0, 0);
        send_instr(OP_BRT, 0, 0, 10'd5);
        send_instr(OP_ADD, 0, 0, 0);
        send_instr(OP_PRINTV, 0, 6'd63, 0);
        send_instr(OP_PUSHC, 32'h8000_0000, 0, 0);
        send_instr(OP_PUSHC, 32'hffff_ffff, 0, 0);
        send_instr(OP_DIV, 0, 0, 0);
        send_instr(OP_PUSHC, 0, 0, 0);
        send_instr(OP_DIV, 0, 0, 0);
        send_instr(OP_POPV, 0, 6'd0, 0);
        send_instr(OP_POPV, 0, 6'd63, 0);
        send_instr(OP_PUSHV, 0, 6'd63, 0);
        send_instr(OP_PRINTC, 32'h7fff_ffff, 0, 0);
        send_instr(OP_JMP, 0, 0, 10'd1023);
        send_instr(OP_NOP, 0, 0, 0);
        send_instr(5'd31, 0, 0, 0);
        send_instr(OP_SIGEN, 0, 0, 0);
        send_instr(OP_SIGDIS, 0, 0, 0);
        send_instr(OP_BRF, 0, 0, 10'd0);
        for (int i = 0; i < 66; i++) send_instr(OP_PUSHC, i, 0, 0);
        for (op = OP_ADD; op <= OP_NEQ; op++) send_instr(op, 0, 0, 0);

        // random: mostly stack-balanced programs, a few halts near the end
        while (sent < 1300) begin
            if (sent == 500) begin
                drain();
            end
            if (sent == 700) hold_out = 1;
            model_depth = sb.depth;
            r = $urandom_range(0, 99);
            if (r < 30 && model_depth < 60 || model_depth < 2 && r < 70)
                op = $urandom_range(0, 1) ? OP_PUSHC : OP_PUSHV;
            else if (r < 55) op = 5'($urandom_range(OP_ADD, OP_NEQ));
            else if (r < 98) op = 5'($urandom_range(OP_POPV, OP_NOP));
            else op = 5'($urandom_range(24, 31));
            if (op == OP_HALT && sent < 1280) op = OP_NOP;
            send_gap(op, rand_word(), 6'($urandom), 10'($urandom));
        end
        drain();
        $display("ran %0d instructions, %0d results checked, final depth %0d",
                 sent, sb.checked, sb.depth);
        if (sb.errors == 0 && sb.q_pc.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
